// File: rtl/core/trpc_pkg.sv
// Shared types and constants for the two-room people counter.
`timescale 1ns / 1ps

package trpc_pkg;

  // Configuration register indexes (byte address = 4 * index)
  localparam int unsigned RegAddrW = 4;
  localparam logic [1:0] REG_WIN_START = 2'd0;
  localparam logic [1:0] REG_WIN_END   = 2'd1;
  localparam logic [1:0] REG_TICK_LIM  = 2'd2;

  // Reset values
  localparam logic [16:0] WIN_START_RST = 17'd57600;
  localparam logic [16:0] WIN_END_RST   = 17'd60300;
  localparam logic [7:0]  TICK_LIM_RST  = 8'd2;
  localparam logic [7:0]  ROOM_TWO_RST  = 8'd2;
  localparam logic [7:0]  ROOM_ONE_RST  = 8'd0;

  // Bit positions inside the stored sensor level word
  localparam int unsigned LV_HIGH = 0;
  localparam int unsigned LV_LOW1 = 1;
  localparam int unsigned LV_LOW2 = 2;
  localparam int unsigned LV_MAG  = 3;
  localparam logic [3:0]  LEVELS_RST = 4'b0111;

  // Item kinds
  localparam logic REQ_SAMPLE = 1'b0;
  localparam logic REQ_TICK   = 1'b1;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_CHILD_12 = 3'd1,
    EV_ADULT_12 = 3'd2,
    EV_CHILD_21 = 3'd3,
    EV_ADULT_21 = 3'd4,
    EV_CLOSED   = 3'd5,
    EV_OPENED   = 3'd6
  } trpc_event_e;

  typedef struct packed {
    logic        req_type;
    logic        high_beam_level;
    logic        low_beam_one_level;
    logic        low_beam_two_level;
    logic        magnet_level;
    logic [16:0] time_of_day;
  } trpc_item_t;

  typedef struct packed {
    logic [7:0]  room_one_count;
    logic [7:0]  room_two_count;
    logic        room_one_lamp;
    logic        room_two_lamp;
    logic        buzzer_on;
    logic        window_is_open;
    trpc_event_e event_code;
  } trpc_res_t;

  typedef struct packed {
    logic [16:0] win_start;
    logic [16:0] win_end;
    logic [7:0]  tick_limit;
  } trpc_cfg_t;

endpackage

// File: rtl/core/trpc_if.sv
// Handshake channel interfaces for sensor items and counter results.
`timescale 1ns / 1ps

interface trpc_in_if;
  logic        valid;
  logic        ready;
  logic        req_type;
  logic        high_beam_level;
  logic        low_beam_one_level;
  logic        low_beam_two_level;
  logic        magnet_level;
  logic [16:0] time_of_day;

  modport source (
    output valid, req_type, high_beam_level, low_beam_one_level,
           low_beam_two_level, magnet_level, time_of_day,
    input  ready
  );
  modport sink (
    input  valid, req_type, high_beam_level, low_beam_one_level,
           low_beam_two_level, magnet_level, time_of_day,
    output ready
  );
endinterface

interface trpc_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] room_one_count;
  logic [7:0] room_two_count;
  logic       room_one_lamp;
  logic       room_two_lamp;
  logic       buzzer_on;
  logic       window_is_open;
  logic [2:0] event_code;

  modport source (
    output valid, room_one_count, room_two_count, room_one_lamp, room_two_lamp,
           buzzer_on, window_is_open, event_code,
    input  ready
  );
  modport sink (
    input  valid, room_one_count, room_two_count, room_one_lamp, room_two_lamp,
           buzzer_on, window_is_open, event_code,
    output ready
  );
endinterface

// File: rtl/core/trpc_cfg_regs.sv
// APB-style configuration registers: alarm window and buzzer tick limit.
`timescale 1ns / 1ps

module trpc_cfg_regs (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trpc_pkg::RegAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  output trpc_pkg::trpc_cfg_t           cfg_o
);

  logic [16:0] win_start_q;
  logic [16:0] win_end_q;
  logic [7:0]  tick_lim_q;
  logic        wr_en;
  logic [1:0]  reg_idx;

  assign pready  = 1'b1;
  assign wr_en   = psel & penable & pwrite & pready;
  assign reg_idx = paddr[3:2];

  // Register writes; unknown indexes are dropped
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_start_q <= trpc_pkg::WIN_START_RST;
      win_end_q   <= trpc_pkg::WIN_END_RST;
      tick_lim_q  <= trpc_pkg::TICK_LIM_RST;
    end else if (wr_en) begin
      case (reg_idx)
        trpc_pkg::REG_WIN_START: win_start_q <= pwdata[16:0];
        trpc_pkg::REG_WIN_END:   win_end_q   <= pwdata[16:0];
        trpc_pkg::REG_TICK_LIM:  tick_lim_q  <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Read-back mux
  always_comb begin
    case (reg_idx)
      trpc_pkg::REG_WIN_START: prdata = {15'd0, win_start_q};
      trpc_pkg::REG_WIN_END:   prdata = {15'd0, win_end_q};
      trpc_pkg::REG_TICK_LIM:  prdata = {24'd0, tick_lim_q};
      default:                 prdata = 32'd0;
    endcase
  end

  assign cfg_o.win_start  = win_start_q;
  assign cfg_o.win_end    = win_end_q;
  assign cfg_o.tick_limit = tick_lim_q;

endmodule

// File: rtl/core/trpc_core.sv
// Counter state and the combinational update for one sample or tick item.
`timescale 1ns / 1ps

module trpc_core (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 en_i,
  input  trpc_pkg::trpc_item_t item_i,
  input  trpc_pkg::trpc_cfg_t  cfg_i,
  output trpc_pkg::trpc_res_t  res_o
);

  localparam logic DIR_ONE_TWO = 1'b0;
  localparam logic DIR_TWO_ONE = 1'b1;

  logic [3:0] prev_q, prev_d;
  logic       started_q, started_d;
  logic       dir_q, dir_d;
  logic       tall_q, tall_d;
  logic [7:0] r1_q, r1_d;
  logic [7:0] r2_q, r2_d;
  logic       win_q, win_d;
  logic       alarm_q, alarm_d;
  logic [7:0] ticks_q, ticks_d;
  logic [3:0] lv;
  logic [3:0] chg;
  logic [7:0] tick_inc;
  logic       in_window;
  trpc_pkg::trpc_event_e ev;

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    return (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  function automatic logic [7:0] sat_dec(input logic [7:0] v);
    return (v == 8'd0) ? v : v - 8'd1;
  endfunction

  assign lv = {item_i.magnet_level, item_i.low_beam_two_level,
               item_i.low_beam_one_level, item_i.high_beam_level};
  assign chg       = lv ^ prev_q;
  assign tick_inc  = ticks_q + 8'd1;
  assign in_window = (cfg_i.win_start < item_i.time_of_day) &&
                     (item_i.time_of_day < cfg_i.win_end);

  // Next state: edges handled high beam, low one, low two, magnet
  always_comb begin
    prev_d    = prev_q;
    started_d = started_q;
    dir_d     = dir_q;
    tall_d    = tall_q;
    r1_d      = r1_q;
    r2_d      = r2_q;
    win_d     = win_q;
    alarm_d   = alarm_q;
    ticks_d   = ticks_q;
    ev        = trpc_pkg::EV_NONE;
    if (item_i.req_type == trpc_pkg::REQ_TICK) begin
      if (alarm_q) begin
        if (tick_inc == cfg_i.tick_limit) begin
          ticks_d = 8'd0;
          alarm_d = 1'b0;
        end else begin
          ticks_d = tick_inc;
        end
      end
    end else begin
      prev_d = lv;
      if (chg[trpc_pkg::LV_HIGH] && !lv[trpc_pkg::LV_HIGH]) begin
        tall_d = 1'b1;
      end
      // room one side beam
      if (chg[trpc_pkg::LV_LOW1]) begin
        if (!lv[trpc_pkg::LV_LOW1]) begin
          if (!started_d) begin
            started_d = 1'b1;
            dir_d     = DIR_ONE_TWO;
          end
        end else if (started_d && dir_d == DIR_TWO_ONE) begin
          ev        = tall_d ? trpc_pkg::EV_ADULT_21 : trpc_pkg::EV_CHILD_21;
          started_d = 1'b0;
          tall_d    = 1'b0;
          r2_d      = sat_dec(r2_d);
          r1_d      = sat_inc(r1_d);
        end
      end
      // room two side beam
      if (chg[trpc_pkg::LV_LOW2]) begin
        if (!lv[trpc_pkg::LV_LOW2]) begin
          if (!started_d) begin
            started_d = 1'b1;
            dir_d     = DIR_TWO_ONE;
          end
        end else if (started_d && dir_d == DIR_ONE_TWO) begin
          ev        = tall_d ? trpc_pkg::EV_ADULT_12 : trpc_pkg::EV_CHILD_12;
          started_d = 1'b0;
          tall_d    = 1'b0;
          r1_d      = sat_dec(r1_d);
          r2_d      = sat_inc(r2_d);
        end
      end
      // window magnet; retrigger leaves the tick count alone
      if (chg[trpc_pkg::LV_MAG]) begin
        if (!lv[trpc_pkg::LV_MAG]) begin
          win_d = 1'b0;
          ev    = trpc_pkg::EV_CLOSED;
        end else begin
          if (in_window) begin
            alarm_d = 1'b1;
          end
          win_d = 1'b1;
          ev    = trpc_pkg::EV_OPENED;
        end
      end
    end
  end

  // State registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_q    <= trpc_pkg::LEVELS_RST;
      started_q <= 1'b0;
      dir_q     <= DIR_ONE_TWO;
      tall_q    <= 1'b0;
      r1_q      <= trpc_pkg::ROOM_ONE_RST;
      r2_q      <= trpc_pkg::ROOM_TWO_RST;
      win_q     <= 1'b0;
      alarm_q   <= 1'b0;
      ticks_q   <= 8'd0;
    end else if (en_i) begin
      prev_q    <= prev_d;
      started_q <= started_d;
      dir_q     <= dir_d;
      tall_q    <= tall_d;
      r1_q      <= r1_d;
      r2_q      <= r2_d;
      win_q     <= win_d;
      alarm_q   <= alarm_d;
      ticks_q   <= ticks_d;
    end
  end

  // Result as seen after this item
  assign res_o.room_one_count = r1_d;
  assign res_o.room_two_count = r2_d;
  assign res_o.room_one_lamp  = (r1_d != 8'd0);
  assign res_o.room_two_lamp  = (r2_d != 8'd0);
  assign res_o.buzzer_on      = alarm_d;
  assign res_o.window_is_open = win_d;
  assign res_o.event_code     = ev;

  // Tick count is parked at zero whenever the buzzer is off
  a_ticks_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !alarm_q |-> ticks_q == 8'd0)
    else $error("tick count running with buzzer off");

  // Latched window state follows the stored magnet level
  a_win_magnet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    win_q == prev_q[trpc_pkg::LV_MAG])
    else $error("window flag out of step with magnet level");

  // Ticks leave the stored levels untouched
  a_tick_levels: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i && item_i.req_type == trpc_pkg::REQ_TICK |=> $stable(prev_q))
    else $error("tick item altered sensor levels");

  // Room one count moves by at most one person per item
  a_room_step: assert property (@(posedge clk_i) disable iff (!rst_ni)
    en_i |=> (r1_q == $past(r1_q) || r1_q == $past(r1_q) + 8'd1 ||
              r1_q == $past(r1_q) - 8'd1))
    else $error("room one count jumped");

endmodule

// File: rtl/core/two_room_people_counter_top.sv
// Top level: input register, counter core, result register and config port.
`timescale 1ns / 1ps
// Pipeline: an item is taken into the input register, and its state update goes
// into the result register once that register is free or being drained.
// Throughput: one item per cycle while the result side is ready; the counter state
// update is a single short combinational pass between the two registers.
// Reset (rst_ni, async, active low): no items held, rooms 0 and 2, buzzer and
// window flags clear, beams taken as high, registers at their default values.

module two_room_people_counter_top (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  trpc_in_if.sink                       in_if,
  trpc_out_if.source                    out_if,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [trpc_pkg::RegAddrW-1:0] paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready
);

  trpc_pkg::trpc_cfg_t  cfg;
  trpc_pkg::trpc_item_t in_item;
  trpc_pkg::trpc_item_t item_q;
  trpc_pkg::trpc_res_t  res;
  trpc_pkg::trpc_res_t  res_q;
  logic                 item_vld_q;
  logic                 res_vld_q;
  logic                 in_acc;
  logic                 step;

  trpc_cfg_regs u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_item.req_type           = in_if.req_type;
  assign in_item.high_beam_level    = in_if.high_beam_level;
  assign in_item.low_beam_one_level = in_if.low_beam_one_level;
  assign in_item.low_beam_two_level = in_if.low_beam_two_level;
  assign in_item.magnet_level       = in_if.magnet_level;
  assign in_item.time_of_day        = in_if.time_of_day;

  // Handshake: the held item moves on when the result slot is free or draining
  assign step        = item_vld_q && (!res_vld_q || out_if.ready);
  assign in_if.ready = !item_vld_q || step;
  assign in_acc      = in_if.valid && in_if.ready;

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      item_vld_q <= 1'b0;
      res_vld_q  <= 1'b0;
    end else begin
      if (in_acc) begin
        item_vld_q <= 1'b1;
      end else if (step) begin
        item_vld_q <= 1'b0;
      end
      if (step) begin
        res_vld_q <= 1'b1;
      end else if (out_if.ready) begin
        res_vld_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      item_q <= in_item;
    end
    if (step) begin
      res_q <= res;
    end
  end

  trpc_core u_core (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (step),
    .item_i (item_q),
    .cfg_i  (cfg),
    .res_o  (res)
  );

  assign out_if.valid          = res_vld_q;
  assign out_if.room_one_count = res_q.room_one_count;
  assign out_if.room_two_count = res_q.room_two_count;
  assign out_if.room_one_lamp  = res_q.room_one_lamp;
  assign out_if.room_two_lamp  = res_q.room_two_lamp;
  assign out_if.buzzer_on      = res_q.buzzer_on;
  assign out_if.window_is_open = res_q.window_is_open;
  assign out_if.event_code     = res_q.event_code;

endmodule

// File: dv/trpc_count_checker.sv
// Checker for the two-room people counter: predicts every result and compares it.
`timescale 1ns / 1ps

module trpc_count_checker
  import trpc_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  trpc_in_if                  sensor_mon,
  trpc_out_if                 count_mon,
  input  logic                psel_i,
  input  logic                penable_i,
  input  logic                pwrite_i,
  input  logic                pready_i,
  input  logic [RegAddrW-1:0] paddr_i,
  input  logic [31:0]         pwdata_i,
  output int unsigned         fail_count_o,
  output int unsigned         results_due_o
);

  // Walk direction through the doorway
  localparam logic HEAD_ONE_TO_TWO = 1'b0;
  localparam logic HEAD_TWO_TO_ONE = 1'b1;

  trpc_cfg_t   cfg_q;
  logic [3:0]  last_lv_q;
  logic        walking_q;
  logic        heading_q;
  logic        tall_q;
  logic [7:0]  room_one_q;
  logic [7:0]  room_two_q;
  logic        window_q;
  logic        buzzer_q;
  logic [7:0]  buzz_ticks_q;
  trpc_res_t   counts_due_q[$];

  function automatic logic [7:0] room_up(logic [7:0] n);
    return (n == 8'd255) ? n : n + 8'd1;
  endfunction

  function automatic logic [7:0] room_down(logic [7:0] n);
    return (n == 8'd0) ? n : n - 8'd1;
  endfunction

  // Completed walk: move one person and class the passage
  function automatic trpc_event_e finish_walk(logic head);
    trpc_event_e ev;
    if (head == HEAD_ONE_TO_TWO) begin
      ev         = tall_q ? EV_ADULT_12 : EV_CHILD_12;
      room_one_q = room_down(room_one_q);
      room_two_q = room_up(room_two_q);
    end else begin
      ev         = tall_q ? EV_ADULT_21 : EV_CHILD_21;
      room_two_q = room_down(room_two_q);
      room_one_q = room_up(room_one_q);
    end
    walking_q = 1'b0;
    tall_q    = 1'b0;
    return ev;
  endfunction

  // Advance the room state by one item and give the counts it should show
  function automatic trpc_res_t next_counts(trpc_item_t it);
    logic [3:0]  lv;
    logic [3:0]  flips;
    trpc_event_e ev;
    ev = EV_NONE;
    if (it.req_type == REQ_TICK) begin
      // buzzer timeout: 8-bit count that wraps
      if (buzzer_q) begin
        buzz_ticks_q = buzz_ticks_q + 8'd1;
        if (buzz_ticks_q == cfg_q.tick_limit) begin
          buzz_ticks_q = 8'd0;
          buzzer_q     = 1'b0;
        end
      end
    end else begin
      lv = {it.magnet_level, it.low_beam_two_level, it.low_beam_one_level,
            it.high_beam_level};
      flips     = lv ^ last_lv_q;
      last_lv_q = lv;

      // high beam newly broken marks an adult
      if (flips[LV_HIGH] && !lv[LV_HIGH]) tall_q = 1'b1;

      // room one side
      if (flips[LV_LOW1]) begin
        if (!lv[LV_LOW1]) begin
          if (!walking_q) begin
            walking_q = 1'b1;
            heading_q = HEAD_ONE_TO_TWO;
          end
        end else if (walking_q && heading_q == HEAD_TWO_TO_ONE) begin
          ev = finish_walk(HEAD_TWO_TO_ONE);
        end
      end

      // room two side
      if (flips[LV_LOW2]) begin
        if (!lv[LV_LOW2]) begin
          if (!walking_q) begin
            walking_q = 1'b1;
            heading_q = HEAD_TWO_TO_ONE;
          end
        end else if (walking_q && heading_q == HEAD_ONE_TO_TWO) begin
          ev = finish_walk(HEAD_ONE_TO_TWO);
        end
      end

      // window: an opening strictly inside the armed window sets the buzzer
      if (flips[LV_MAG]) begin
        if (!lv[LV_MAG]) begin
          window_q = 1'b0;
          ev       = EV_CLOSED;
        end else begin
          if (cfg_q.win_start < it.time_of_day && it.time_of_day < cfg_q.win_end) begin
            buzzer_q = 1'b1;
          end
          window_q = 1'b1;
          ev       = EV_OPENED;
        end
      end
    end
    return '{room_one_q, room_two_q, room_one_q != 8'd0, room_two_q != 8'd0,
             buzzer_q, window_q, ev};
  endfunction

  // Every mismatch is counted and printed
  task automatic check_field(string name, logic [7:0] want, logic [7:0] got);
    if (want != got) begin
      fail_count_o++;
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
    end
  endtask

  // Register writes, result transactions, then sensor transactions, all per edge
  always @(posedge clk_i or negedge rst_ni) begin
    trpc_item_t item;
    trpc_res_t  want;
    if (!rst_ni) begin
      cfg_q         = '{WIN_START_RST, WIN_END_RST, TICK_LIM_RST};
      last_lv_q     = LEVELS_RST;
      walking_q     = 1'b0;
      heading_q     = HEAD_ONE_TO_TWO;
      tall_q        = 1'b0;
      room_one_q    = ROOM_ONE_RST;
      room_two_q    = ROOM_TWO_RST;
      window_q      = 1'b0;
      buzzer_q      = 1'b0;
      buzz_ticks_q  = 8'd0;
      counts_due_q.delete();
      fail_count_o  = 0;
      results_due_o = 0;
    end else begin
      if (psel_i && penable_i && pwrite_i && pready_i) begin
        case (paddr_i[RegAddrW-1:2])
          REG_WIN_START: cfg_q.win_start  = pwdata_i[16:0];
          REG_WIN_END:   cfg_q.win_end    = pwdata_i[16:0];
          REG_TICK_LIM:  cfg_q.tick_limit = pwdata_i[7:0];
          default: ;
        endcase
      end

      if (count_mon.valid && count_mon.ready) begin
        if (counts_due_q.size() == 0) begin
          fail_count_o++;
          $display("%0t: result transaction expected none, got event %0d rooms %0d/%0d",
                   $time, count_mon.event_code, count_mon.room_one_count,
                   count_mon.room_two_count);
        end else begin
          want = counts_due_q.pop_front();
          check_field("room_one_count", want.room_one_count, count_mon.room_one_count);
          check_field("room_two_count", want.room_two_count, count_mon.room_two_count);
          check_field("room_one_lamp", 8'(want.room_one_lamp),
                      8'(count_mon.room_one_lamp));
          check_field("room_two_lamp", 8'(want.room_two_lamp),
                      8'(count_mon.room_two_lamp));
          check_field("buzzer_on", 8'(want.buzzer_on), 8'(count_mon.buzzer_on));
          check_field("window_is_open", 8'(want.window_is_open),
                      8'(count_mon.window_is_open));
          check_field("event_code", 8'(want.event_code), 8'(count_mon.event_code));
        end
      end

      if (sensor_mon.valid && sensor_mon.ready) begin
        item.req_type           = sensor_mon.req_type;
        item.high_beam_level    = sensor_mon.high_beam_level;
        item.low_beam_one_level = sensor_mon.low_beam_one_level;
        item.low_beam_two_level = sensor_mon.low_beam_two_level;
        item.magnet_level       = sensor_mon.magnet_level;
        item.time_of_day        = sensor_mon.time_of_day;
        counts_due_q.push_back(next_counts(item));
      end
      results_due_o = counts_due_q.size();
    end
  end

endmodule

// File: dv/two_room_people_counter_top_test.sv
// Testbench top for the two-room people counter: stimulus, stalls and verdict.
`timescale 1ns / 1ps

module two_room_people_counter_top_test;
  import trpc_pkg::*;

  localparam int unsigned STALL_LIMIT = 1000;
  localparam logic [1:0]  REG_SPARE   = 2'd3;

  logic                clk_i  = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel;
  logic                penable;
  logic                pwrite;
  logic [RegAddrW-1:0] paddr;
  logic [31:0]         pwdata;
  logic [31:0]         prdata;
  logic                pready;

  int unsigned fail_count;
  int unsigned results_due;
  int unsigned quiet_cycles;
  int unsigned items_sent;

  // Stimulus side copies: levels last driven {magnet, low two, low one, high}
  logic [3:0]  lv_now;
  logic [16:0] win_lo;
  logic [16:0] win_hi;
  logic [7:0]  tick_lim;
  bit          sender_calm;

  trpc_in_if  sensor_ch ();
  trpc_out_if count_ch ();

  always #5 clk_i = ~clk_i;

  two_room_people_counter_top u_dut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .in_if   (sensor_ch),
    .out_if  (count_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  trpc_count_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .sensor_mon    (sensor_ch),
    .count_mon     (count_ch),
    .psel_i        (psel),
    .penable_i     (penable),
    .pwrite_i      (pwrite),
    .pready_i      (pready),
    .paddr_i       (paddr),
    .pwdata_i      (pwdata),
    .fail_count_o  (fail_count),
    .results_due_o (results_due)
  );

  // Watchdog: ends the run when no transaction is seen for too long
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      quiet_cycles <= 0;
    end else if ((sensor_ch.valid && sensor_ch.ready) || (count_ch.valid && count_ch.ready) ||
                 (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Mostly short idle spells, a few long ones
  function automatic int unsigned idle_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Time of day, biased towards the armed window and its edges
  function automatic logic [16:0] pick_time();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 4) return 17'($urandom_range(win_lo, win_hi));
    if (r == 4) begin
      case ($urandom_range(0, 3))
        0:       return win_lo;
        1:       return win_hi;
        2:       return win_lo + 17'd1;
        default: return win_hi - 17'd1;
      endcase
    end
    if (r == 5) return $urandom_range(0, 1) ? 17'h1FFFF : 17'd0;
    return 17'($urandom_range(0, 86399));
  endfunction

  // Result side back-pressure, with calm stretches of no stalling
  initial begin
    int unsigned hold;
    int unsigned calm;
    hold = 0;
    calm = 0;
    count_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (calm > 0) begin
        calm--;
      end else if ($urandom_range(0, 99) == 0) begin
        calm = $urandom_range(30, 120);
      end
      if (hold > 0) begin
        hold--;
        count_ch.ready <= 1'b0;
      end else begin
        count_ch.ready <= 1'b1;
        if (calm == 0 && $urandom_range(0, 3) == 0) hold = idle_len();
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the transaction
  task automatic send_item(trpc_item_t it);
    int unsigned gap;
    gap = (sender_calm || $urandom_range(0, 2) != 0) ? 0 : idle_len();
    if (gap > 0) begin
      sensor_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    sensor_ch.valid              <= 1'b1;
    sensor_ch.req_type           <= it.req_type;
    sensor_ch.high_beam_level    <= it.high_beam_level;
    sensor_ch.low_beam_one_level <= it.low_beam_one_level;
    sensor_ch.low_beam_two_level <= it.low_beam_two_level;
    sensor_ch.magnet_level       <= it.magnet_level;
    sensor_ch.time_of_day        <= it.time_of_day;
    do @(posedge clk_i); while (!sensor_ch.ready);
    items_sent++;
    @(negedge clk_i);
  endtask

  task automatic drive_levels(bit h, bit l1, bit l2, bit m, logic [16:0] t);
    trpc_item_t it;
    it     = '{REQ_SAMPLE, h, l1, l2, m, t};
    lv_now = {m, l2, l1, h};
    send_item(it);
  endtask

  // Timer tick; level and time fields carry junk
  task automatic tick();
    trpc_item_t it;
    it          = trpc_item_t'($urandom());
    it.req_type = REQ_TICK;
    send_item(it);
  endtask

  // head 0 walks from room one to two; fb/sb: entry/exit side low beam broken
  task automatic step_walk(bit head, bit h, bit fb, bit sb);
    if ($urandom_range(0, 7) == 0) tick();
    if (head == 1'b0) begin
      drive_levels(h, !fb, !sb, lv_now[LV_MAG], pick_time());
    end else begin
      drive_levels(h, !sb, !fb, lv_now[LV_MAG], pick_time());
    end
  endtask

  task automatic write_reg(logic [1:0] idx, logic [31:0] val);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(negedge clk_i);
  endtask

  // Let the counter drain, then load a new window and buzzer timeout
  task automatic configure(logic [16:0] lo, logic [16:0] hi, logic [7:0] lim);
    sensor_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
    write_reg(REG_WIN_START, {15'($urandom()), lo});
    write_reg(REG_WIN_END, {15'($urandom()), hi});
    write_reg(REG_TICK_LIM, {24'($urandom()), lim});
    win_lo   = lo;
    win_hi   = hi;
    tick_lim = lim;
  endtask

  // Directed corner cases with the reset window and timeout
  task automatic run_directed();
    tick();                                            // buzzer off: no effect
    drive_levels(1'b1, 1'b1, 1'b1, 1'b0, 17'd0);       // no change at all
    drive_levels(1'b1, 1'b0, 1'b0, 1'b0, 17'd86399);   // both lows at once, one-to-two
    drive_levels(1'b1, 1'b1, 1'b1, 1'b0, 17'd1);       // child one to two, room one floors at 0
    drive_levels(1'b0, 1'b1, 1'b0, 1'b0, 17'd100);     // tall, walking two to one
    drive_levels(1'b1, 1'b0, 1'b0, 1'b0, 17'd200);
    drive_levels(1'b1, 1'b1, 1'b1, 1'b0, 17'd300);     // adult two to one
    drive_levels(1'b1, 1'b0, 1'b1, 1'b0, 17'd400);
    drive_levels(1'b1, 1'b0, 1'b0, 1'b0, 17'd500);
    drive_levels(1'b1, 1'b1, 1'b1, 1'b1, 17'd57601);   // passage hidden by window open, armed
    drive_levels(1'b1, 1'b1, 1'b1, 1'b0, 17'd58000);   // window closed, buzzer stays
    drive_levels(1'b1, 1'b1, 1'b1, 1'b1, 17'd60299);   // reopen while buzzing
    tick();
    tick();                                            // timeout reached
    drive_levels(1'b1, 1'b1, 1'b1, 1'b0, 17'd0);
    drive_levels(1'b1, 1'b1, 1'b1, 1'b1, 17'd57600);   // window start itself is not armed
    drive_levels(1'b1, 1'b1, 1'b1, 1'b0, 17'd0);
    drive_levels(1'b1, 1'b1, 1'b1, 1'b1, 17'd60300);   // window end itself is not armed
    drive_levels(1'b1, 1'b1, 1'b1, 1'b0, 17'd0);
    drive_levels(1'b1, 1'b1, 1'b1, 1'b1, 17'h1FFFF);   // time beyond a day
    send_item('0);                                     // all beams broken, window shut
    send_item('1);                                     // tick with every field high
    drive_levels(1'b1, 1'b1, 1'b1, 1'b1, 17'd59000);   // all released, window opens armed
    tick();
  endtask

  // Mixed random traffic: walks, turn-backs, window toggles, tick bursts, random levels
  task automatic run_mixed(int unsigned n);
    int unsigned stop_at;
    int unsigned r;
    int unsigned burst;
    bit          head;
    bit          adult;
    stop_at = items_sent + n;
    while (items_sent < stop_at) begin
      if ($urandom_range(0, 19) == 0) sender_calm = !sender_calm;
      r     = $urandom_range(0, 99);
      head  = 1'($urandom_range(0, 1));
      adult = 1'($urandom_range(0, 1));
      if (r < 25) begin
        // full walk through the doorway
        step_walk(head, 1'b1, 1'b1, 1'b0);
        if (adult) step_walk(head, 1'b0, 1'b1, 1'b0);
        step_walk(head, 1'b1, 1'b1, 1'b1);
        step_walk(head, 1'b1, 1'b0, 1'b1);
        step_walk(head, 1'b1, 1'b0, 1'b0);
      end else if (r < 45) begin
        // quick walk: both lows in one sample
        step_walk(head, !adult, 1'b1, 1'b1);
        step_walk(head, 1'b1, 1'b0, 1'b0);
      end else if (r < 60) begin
        drive_levels(lv_now[LV_HIGH], lv_now[LV_LOW1], lv_now[LV_LOW2], !lv_now[LV_MAG],
                     pick_time());
      end else if (r < 75) begin
        burst = ($urandom_range(0, 9) == 0) ? tick_lim + $urandom_range(0, 3)
                                            : $urandom_range(1, 6);
        repeat (burst) tick();
      end else if (r < 88) begin
        // turn back in the doorway
        step_walk(head, 1'b1, 1'b1, 1'b0);
        step_walk(head, 1'b1, 1'b0, 1'b0);
      end else if ($urandom_range(0, 3) == 0) begin
        tick();
      end else begin
        drive_levels(1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
                     1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), pick_time());
      end
    end
  endtask

  initial begin
    logic [16:0] lo;
    sensor_ch.valid              = 1'b0;
    sensor_ch.req_type           = REQ_SAMPLE;
    sensor_ch.high_beam_level    = 1'b1;
    sensor_ch.low_beam_one_level = 1'b1;
    sensor_ch.low_beam_two_level = 1'b1;
    sensor_ch.magnet_level       = 1'b0;
    sensor_ch.time_of_day        = 17'd0;
    psel        = 1'b0;
    penable     = 1'b0;
    pwrite      = 1'b0;
    paddr       = '0;
    pwdata      = '0;
    lv_now      = LEVELS_RST;
    win_lo      = WIN_START_RST;
    win_hi      = WIN_END_RST;
    tick_lim    = TICK_LIM_RST;
    items_sent  = 0;
    sender_calm = 1'b0;

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    run_directed();

    // widest window, longest timeout, plus a write to the unused slot
    configure(17'd0, 17'd86399, 8'd255);
    write_reg(REG_SPARE, $urandom());
    run_mixed(60);

    // reversed window never arms; shortest timeout
    configure(17'd86399, 17'd0, 8'd1);
    run_mixed(60);

    // empty window
    lo = 17'($urandom_range(0, 86399));
    configure(lo, lo, 8'($urandom_range(1, 255)));
    run_mixed(80);

    // crowd walking into room two until its counter saturates
    configure(17'd1000, 17'd5000, 8'd3);
    repeat (270) begin
      step_walk(1'b0, 1'($urandom_range(0, 1)), 1'b1, 1'b1);
      step_walk(1'b0, 1'b1, 1'b0, 1'b0);
    end
    run_mixed(40);

    // narrow random windows, short timeouts
    repeat (3) begin
      lo = 17'($urandom_range(0, 84000));
      configure(lo, lo + 17'($urandom_range(2, 2000)), 8'($urandom_range(1, 12)));
      run_mixed(85);
    end

    sensor_ch.valid <= 1'b0;
    while (results_due != 0) @(negedge clk_i);
    repeat (10) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
